// ----- hw/rtl/delta_type_kvp_parser_assert.svh -----
// Assertion macros for the parser top level, delta_type_kvp_parser.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef DELTA_TYPE_KVP_PARSER_ASSERT_SVH
`define DELTA_TYPE_KVP_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DTKP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtkp assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DTKP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtkp assertion failed");

`endif

// ----- hw/rtl/dtkp_pkg.sv -----
// Shared types and codes for the delta-coded key-value-pair parser.
// No dependencies; used by dtkp_core and delta_type_kvp_parser.
`timescale 1ns / 1ps

package dtkp_pkg;

	typedef enum logic [1:0] {
		PH_DELTA   = 2'd0,
		PH_VALUE   = 2'd1,
		PH_LENGTH  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_DELTA   = 3'd0,
		ROLE_VALUE   = 3'd1,
		ROLE_LENGTH  = 3'd2,
		ROLE_PAYLOAD = 3'd3,
		ROLE_DISCARD = 3'd4
	} role_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TYPE_OVF = 2'd1,
		ERR_LEN      = 2'd2,
		ERR_TRUNC    = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} in_item_t;

	typedef struct packed {
		role_t        byte_role;
		logic [7:0]   data;
		logic [63:0]  etype;
		logic         isv;
		logic [15:0]  vlen;
		logic [16:0]  raw;
		logic         done;
		logic         bdone;
		err_t         err;
	} result_t;

endpackage

// ----- hw/rtl/delta_type_kvp_parser.sv -----
// Channel   | Signals                                    | Direction
// item      | item_valid/item_ready, data_byte, first_of_buffer, last_of_buffer | in
// result    | result_valid/result_ready, byte_role .. error_code | out
//
// One byte per cycle sustained while results are taken; a byte's result is offered
// from the result register, behind the input register. The type path (varint shift
// plus a 64-bit add and carry check) sets the cycle time. Reset clears the parser
// to the start of a buffer. A stalled result holds the decode stage; the input
// register still takes one byte, then item_ready drops until the result is taken.
//
// Top level of the parser; depends on dtkp_pkg, dtkp_core and the assert header.
`timescale 1ns / 1ps
`include "delta_type_kvp_parser_assert.svh"

module delta_type_kvp_parser #(
	parameter int unsigned MAX_VALUE_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_of_buffer,
	input  logic        last_of_buffer,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  byte_role,
	output logic [7:0]  data_out,
	output logic [63:0] entry_type,
	output logic        value_is_varint,
	output logic [15:0] value_length,
	output logic [16:0] raw_length,
	output logic        entry_done,
	output logic        buffer_done,
	output logic [1:0]  error_code
);

	dtkp_pkg::in_item_t item_s1;
	logic               valid_s1;
	dtkp_pkg::result_t  res_n;
	dtkp_pkg::result_t  res_s2;
	logic               valid_s2;
	logic               advance;
	logic               out_discard;
	logic               out_clean_end;
	logic               out_closing;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= '{data: data_byte, first: first_of_buffer, last: last_of_buffer};
		end
	end

	dtkp_core #(
		.MAX_VALUE_LENGTH (MAX_VALUE_LENGTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.result  (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign result_valid    = valid_s2;
	assign byte_role       = res_s2.byte_role;
	assign data_out        = res_s2.data;
	assign entry_type      = res_s2.etype;
	assign value_is_varint = res_s2.isv;
	assign value_length    = res_s2.vlen;
	assign raw_length      = res_s2.raw;
	assign entry_done      = res_s2.done;
	assign buffer_done     = res_s2.bdone;
	assign error_code      = res_s2.err;

	assign out_discard   = valid_s2 && res_s2.byte_role == dtkp_pkg::ROLE_DISCARD;
	assign out_clean_end = res_s2.done && res_s2.err == dtkp_pkg::ERR_NONE;
	assign out_closing   = res_s2.byte_role != dtkp_pkg::ROLE_DELTA
		&& res_s2.byte_role != dtkp_pkg::ROLE_DISCARD;

	// A discarded byte only follows a latched error.
	`DTKP_ASSERT_NOW(a_discard_has_err, out_discard, res_s2.err != dtkp_pkg::ERR_NONE)
	// A clean buffer end is always an entry end without error.
	`DTKP_ASSERT_NOW(a_bdone_clean, valid_s2 && res_s2.bdone, out_clean_end)
	// Type-delta and discarded bytes never close an entry.
	`DTKP_ASSERT_NOW(a_done_role, valid_s2 && res_s2.done, out_closing)
	// A byte waiting in the input register is kept until the decode stage takes it.
	`DTKP_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1))
	// Taking a new result while the old one is unread would lose it.
	`DTKP_ASSERT_NOW(a_no_overwrite, advance && valid_s2, result_ready)

endmodule

// ----- hw/rtl/dtkp_varint.sv -----
// One byte step of a QUIC variable-length integer decoder.
// Purely combinational; no package dependencies.
`timescale 1ns / 1ps

module dtkp_varint (
	input  logic        busy,
	input  logic [61:0] acc,
	input  logic [2:0]  left,
	input  logic [7:0]  data,
	output logic [61:0] acc_next,
	output logic [2:0]  left_next,
	output logic        complete
);

	always_comb begin
		if (!busy) begin
			// The two-bit prefix selects 1, 2, 4 or 8 bytes in total.
			acc_next = {56'd0, data[5:0]};
			unique case (data[7:6])
				2'd0: left_next = 3'd0;
				2'd1: left_next = 3'd1;
				2'd2: left_next = 3'd3;
				default: left_next = 3'd7;
			endcase
		end else begin
			acc_next  = {acc[53:0], data};
			left_next = left - 3'd1;
		end
		complete = (left_next == 3'd0);
	end

endmodule

// ----- hw/rtl/dtkp_core.sv -----
// Parser state and per-byte decode: one byte in, one result out, same cycle.
// Depends on dtkp_pkg and dtkp_varint.
`timescale 1ns / 1ps

module dtkp_core #(
	parameter int unsigned MAX_VALUE_LENGTH = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  dtkp_pkg::in_item_t item,
	output dtkp_pkg::result_t  result
);

	typedef struct packed {
		logic             fep;
		logic [63:0]      prev;
		logic [63:0]      cur;
		dtkp_pkg::phase_t phase;
		logic [61:0]      acc;
		logic [2:0]       left;
		logic             busy;
		logic [15:0]      pbl;
		logic [16:0]      cnt;
		dtkp_pkg::err_t   err;
		logic [15:0]      held;
	} kvp_state_t;

	localparam kvp_state_t StReset = '{
		fep:   1'b1,
		prev:  64'd0,
		cur:   64'd0,
		phase: dtkp_pkg::PH_DELTA,
		acc:   62'd0,
		left:  3'd0,
		busy:  1'b0,
		pbl:   16'd0,
		cnt:   17'd0,
		err:   dtkp_pkg::ERR_NONE,
		held:  16'd0
	};

	kvp_state_t  st_q;
	kvp_state_t  st_e;
	kvp_state_t  st_n;
	logic [61:0] vacc;
	logic [2:0]  vleft;
	logic        vdone;
	logic [64:0] sum;
	logic [63:0] type_v;
	logic [15:0] size_v;

	// A first mark drops whatever the previous buffer left behind.
	assign st_e = item.first ? StReset : st_q;
	assign sum  = {1'b0, st_e.prev} + {3'd0, vacc};

	dtkp_varint u_varint (
		.busy      (st_e.busy),
		.acc       (st_e.acc),
		.left      (st_e.left),
		.data      (item.data),
		.acc_next  (vacc),
		.left_next (vleft),
		.complete  (vdone)
	);

	always_comb begin
		unique case (item.data[7:6])
			2'd0: size_v = 16'd1;
			2'd1: size_v = 16'd2;
			2'd2: size_v = 16'd4;
			default: size_v = 16'd8;
		endcase
	end

	always_comb begin
		st_n   = st_e;
		type_v = st_e.fep ? {2'd0, vacc} : sum[63:0];
		result = '{
			byte_role: dtkp_pkg::ROLE_DISCARD,
			data:      item.data,
			etype:     64'd0,
			isv:       1'b0,
			vlen:      16'd0,
			raw:       17'd0,
			done:      1'b0,
			bdone:     1'b0,
			err:       dtkp_pkg::ERR_NONE
		};
		if (st_e.err == dtkp_pkg::ERR_NONE) begin
			st_n.cnt = st_e.cnt + 17'd1;
			unique case (st_e.phase)
				dtkp_pkg::PH_DELTA: begin
					result.byte_role = dtkp_pkg::ROLE_DELTA;
					st_n.acc  = vacc;
					st_n.left = vleft;
					st_n.busy = !vdone;
					if (vdone) begin
						if (!st_e.fep && sum[64]) begin
							st_n.err = dtkp_pkg::ERR_TYPE_OVF;
						end else begin
							st_n.cur   = type_v;
							st_n.prev  = type_v;
							st_n.fep   = 1'b0;
							st_n.phase = type_v[0] ? dtkp_pkg::PH_LENGTH
								: dtkp_pkg::PH_VALUE;
							result.etype = type_v;
							result.isv   = !type_v[0];
						end
					end
				end
				dtkp_pkg::PH_VALUE: begin
					result.byte_role = dtkp_pkg::ROLE_VALUE;
					result.etype     = st_e.cur;
					result.isv       = 1'b1;
					// The encoded size is taken from the first byte of the value.
					if (!st_e.busy) begin
						st_n.held = size_v;
					end
					result.vlen = st_n.held;
					st_n.acc    = vacc;
					st_n.left   = vleft;
					st_n.busy   = !vdone;
					result.done = vdone;
				end
				dtkp_pkg::PH_LENGTH: begin
					result.byte_role = dtkp_pkg::ROLE_LENGTH;
					result.etype     = st_e.cur;
					st_n.acc  = vacc;
					st_n.left = vleft;
					st_n.busy = !vdone;
					if (vdone) begin
						if (vacc > 62'(MAX_VALUE_LENGTH)) begin
							st_n.err = dtkp_pkg::ERR_LEN;
						end else begin
							st_n.held   = vacc[15:0];
							result.vlen = vacc[15:0];
							if (vacc[15:0] == 16'd0) begin
								result.done = 1'b1;
							end else begin
								st_n.pbl   = vacc[15:0];
								st_n.phase = dtkp_pkg::PH_PAYLOAD;
							end
						end
					end
				end
				default: begin
					result.byte_role = dtkp_pkg::ROLE_PAYLOAD;
					result.etype     = st_e.cur;
					result.vlen      = st_e.held;
					st_n.pbl         = st_e.pbl - 16'd1;
					result.done      = (st_n.pbl == 16'd0);
				end
			endcase
			result.raw = st_n.cnt;
			if (result.done) begin
				st_n.phase = dtkp_pkg::PH_DELTA;
				st_n.cnt   = 17'd0;
			end
			if (item.last && st_n.err == dtkp_pkg::ERR_NONE) begin
				if (result.done) begin
					result.bdone = 1'b1;
				end else begin
					st_n.err = dtkp_pkg::ERR_TRUNC;
				end
			end
		end
		result.err = st_n.err;
		// The byte after a last mark always opens a fresh buffer.
		if (item.last) begin
			st_n = StReset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StReset;
		end else if (step_en) begin
			st_q <= st_n;
		end
	end

endmodule
